// ----- rtl/core/dol_pkg.sv -----
// Package with shared types, codes and constants of the debounce and obstruction latch.
package dol_pkg;

    // Default width of each disagree counter.
    localparam int DOL_COUNT_WIDTH = 8;

    localparam int NUM_PINS = 5;

    // Pin positions in the debounced pin vector.
    localparam int PIN_BUTTON = 0;
    localparam int PIN_ESTOP  = 1;
    localparam int PIN_XLOCK  = 2;
    localparam int PIN_YLOCK  = 3;
    localparam int PIN_AIR    = 4;

    // Debounced levels after reset: estop and both locks high.
    localparam logic [NUM_PINS-1:0] PIN_RESET_LEVELS = 5'b01110;

    // Acknowledge bit positions.
    localparam int ACK_LOCK    = 0;
    localparam int ACK_OBS     = 1;
    localparam int ACK_WARNING = 2;
    localparam int ACK_BUTTON  = 3;
    localparam int ACK_AIR     = 4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_OBSTRUCTION_MASK      = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE_LENGTH       = 2'd1;
    localparam logic [1:0] CFG_XLOCK_DEBOUNCE_LENGTH = 2'd2;

    // Register reset values.
    localparam logic [7:0] OBS_MASK_RESET   = 8'd255;
    localparam logic [7:0] DEBOUNCE_RESET   = 8'd3;

    // Air event value meaning no flip pending.
    localparam logic [1:0] AIR_NONE = 2'd2;

    typedef struct packed {
        logic [4:0] debounce_pins;
        logic [3:0] obstruction_pins;
        logic [1:0] limit_pins;
        logic [1:0] motion_obstruct;
        logic       soft_stop_pin;
        logic [4:0] ack_events;
        logic [7:0] ack_new_flags;
    } t_in_item;

    typedef struct packed {
        logic [4:0] debounced_levels;
        logic [1:0] machine_lock;
        logic       lock_event;
        logic [7:0] obstruction_code;
        logic [7:0] new_obstruction;
        logic       obstruction_event;
        logic       warning_active;
        logic       warning_event;
        logic       button_event;
        logic [1:0] air_event;
        logic       stop_request;
    } t_out_item;

    // Debounce status handed to the event logic.
    typedef struct packed {
        logic [NUM_PINS-1:0] levels;
        logic [NUM_PINS-1:0] flips;
    } t_pin_status;

endpackage

// ----- rtl/core/dol_in_if.sv -----
// Interface of the sample input channel.
interface dol_in_if;
    logic              valid;
    logic              ready;
    dol_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/dol_out_if.sv -----
// Interface of the result output channel.
interface dol_out_if;
    logic               valid;
    logic               ready;
    dol_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/core/dol_debounce.sv -----
// Counter-based debouncer for one pin.
module dol_debounce #(
    parameter int   COUNT_WIDTH = 8,
    parameter logic RESET_LEVEL = 1'b0
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  logic       i_raw,
    input  logic [7:0] i_len,
    output logic       o_level_n,
    output logic       o_flip
);
    localparam int CMP_W = (COUNT_WIDTH > 8) ? COUNT_WIDTH : 8;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};
    localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

    logic                   r_level;
    logic [COUNT_WIDTH-1:0] r_cnt;
    logic [COUNT_WIDTH-1:0] n_cnt;
    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic                   disagree;

    // Saturating count of disagreeing samples and flip decision.
    always_comb begin
        disagree = (i_raw != r_level);
        cnt_inc  = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_ONE;
        o_flip   = disagree && (CMP_W'(cnt_inc) >= CMP_W'(i_len));
        if (!disagree || o_flip) begin
            n_cnt = '0;
        end else begin
            n_cnt = cnt_inc;
        end
        o_level_n = r_level ^ o_flip;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= RESET_LEVEL;
            r_cnt   <= CNT_ONE;
        end else if (i_en) begin
            r_level <= o_level_n;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- rtl/core/dol_events.sv -----
// Lock, obstruction, warning, button, air and stop event latches.
module dol_events (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  dol_pkg::t_in_item  i_item,
    input  dol_pkg::t_pin_status i_pins,
    input  logic [7:0]         i_obs_mask,
    output dol_pkg::t_out_item o_item
);
    import dol_pkg::*;

    logic       r_lock_flag;
    logic [1:0] r_lock_mask;
    logic [7:0] r_last_code;
    logic [7:0] r_new_flags;
    logic       r_code_flag;
    logic       r_last_warning;
    logic       r_warning_flag;
    logic       r_button_flag;
    logic [1:0] r_air_flag;
    logic       r_soft_stop;

    logic       n_lock_flag;
    logic [1:0] n_lock_mask;
    logic [7:0] n_last_code;
    logic [7:0] n_new_flags;
    logic       n_code_flag;
    logic       n_last_warning;
    logic       n_warning_flag;
    logic       n_button_flag;
    logic [1:0] n_air_flag;
    logic       stop;
    logic [7:0] code;
    logic       warn;

    // Acknowledges apply first, then this sample's events are raised.
    always_comb begin
        n_lock_flag = r_lock_flag & ~i_item.ack_events[ACK_LOCK];
        if (i_pins.flips[PIN_XLOCK] || i_pins.flips[PIN_YLOCK]) begin
            n_lock_flag = 1'b1;
        end
        n_lock_mask = n_lock_flag ? {~i_pins.levels[PIN_YLOCK], ~i_pins.levels[PIN_XLOCK]}
                                  : r_lock_mask;

        code = {i_item.motion_obstruct[1], i_item.motion_obstruct[0],
                ~i_item.limit_pins[1], ~i_item.limit_pins[0],
                1'b0, i_item.obstruction_pins[2:0]} & i_obs_mask;
        n_new_flags = r_new_flags & ~i_item.ack_new_flags;
        n_code_flag = r_code_flag & ~i_item.ack_events[ACK_OBS];
        n_last_code = code;
        if (code != r_last_code) begin
            n_new_flags = n_new_flags | (code & ~r_last_code);
            n_code_flag = 1'b1;
        end

        warn           = i_item.obstruction_pins[3];
        n_last_warning = warn;
        n_warning_flag = r_warning_flag & ~i_item.ack_events[ACK_WARNING];
        if (warn != r_last_warning) begin
            n_warning_flag = 1'b1;
        end

        n_button_flag = r_button_flag & ~i_item.ack_events[ACK_BUTTON];
        if (i_pins.flips[PIN_BUTTON]) begin
            n_button_flag = i_item.debounce_pins[PIN_BUTTON];
        end
        n_air_flag = i_item.ack_events[ACK_AIR] ? AIR_NONE : r_air_flag;
        if (i_pins.flips[PIN_AIR]) begin
            n_air_flag = {1'b0, i_item.debounce_pins[PIN_AIR]};
        end

        // Stop request on a falling soft stop level.
        stop = r_soft_stop & ~i_item.soft_stop_pin;
    end

    // Result of this sample as seen after the update.
    always_comb begin
        o_item.debounced_levels  = i_pins.levels;
        o_item.machine_lock      = n_lock_mask;
        o_item.lock_event        = n_lock_flag;
        o_item.obstruction_code  = n_last_code;
        o_item.new_obstruction   = n_new_flags;
        o_item.obstruction_event = n_code_flag;
        o_item.warning_active    = n_last_warning;
        o_item.warning_event     = n_warning_flag;
        o_item.button_event      = n_button_flag;
        o_item.air_event         = n_air_flag;
        o_item.stop_request      = stop;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lock_flag    <= 1'b0;
            r_lock_mask    <= '0;
            r_last_code    <= '0;
            r_new_flags    <= '0;
            r_code_flag    <= 1'b0;
            r_last_warning <= 1'b0;
            r_warning_flag <= 1'b0;
            r_button_flag  <= 1'b0;
            r_air_flag     <= AIR_NONE;
            r_soft_stop    <= 1'b1;
        end else if (i_en) begin
            r_lock_flag    <= n_lock_flag;
            r_lock_mask    <= n_lock_mask;
            r_last_code    <= n_last_code;
            r_new_flags    <= n_new_flags;
            r_code_flag    <= n_code_flag;
            r_last_warning <= n_last_warning;
            r_warning_flag <= n_warning_flag;
            r_button_flag  <= n_button_flag;
            r_air_flag     <= n_air_flag;
            r_soft_stop    <= i_item.soft_stop_pin;
        end
    end

    // The air event never holds the unused code three.
    a_air_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_air_flag != 2'd3)
        else $error("air event holds an illegal code");

    // A lock flip always leaves the lock event pending after the sample.
    a_lock_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && (i_pins.flips[PIN_XLOCK] || i_pins.flips[PIN_YLOCK]) |=> r_lock_flag)
        else $error("lock flip did not raise the lock event");

    // A stop request needs the soft stop level to have been high before.
    a_stop_edge: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && stop |=> !r_soft_stop && $past(r_soft_stop))
        else $error("stop request without a falling soft stop");

endmodule

// ----- rtl/core/debounce_obstruction_latch.sv -----
// Top level of the debounce and obstruction latch.
// Latency: a result is valid in the cycle after its sample transaction is accepted.
// Throughput: one sample per cycle unless the output stalls; the result register frees as it is taken.
// Each sample updates the five pin debouncers and the event latches in a single pass.
// Reset is synchronous and active low; it restores all pins, counters, events and
// configuration registers at once, so no clearing pass is needed.
module debounce_obstruction_latch #(
    parameter int COUNT_WIDTH = dol_pkg::DOL_COUNT_WIDTH
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dol_in_if.sink     i_in,
    dol_out_if.source  o_out,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);
    import dol_pkg::*;

    logic [7:0]  r_obs_mask;
    logic [7:0]  r_len;
    logic [7:0]  r_xlen;
    logic        r_out_valid;
    t_out_item   r_out;
    t_out_item   n_out;
    t_pin_status pins;
    logic        accept;

    // Configuration register writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_obs_mask <= OBS_MASK_RESET;
            r_len      <= DEBOUNCE_RESET;
            r_xlen     <= DEBOUNCE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_OBSTRUCTION_MASK:      r_obs_mask <= i_cfg_data;
                CFG_DEBOUNCE_LENGTH:       r_len      <= i_cfg_data;
                CFG_XLOCK_DEBOUNCE_LENGTH: r_xlen     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input is taken whenever the result register is empty or being drained.
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && i_in.ready;

    // One debouncer per pin.
    for (genvar g = 0; g < NUM_PINS; g++) begin : g_pin
        dol_debounce #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .RESET_LEVEL (PIN_RESET_LEVELS[g])
        ) u_debounce (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_en      (accept),
            .i_raw     (i_in.data.debounce_pins[g]),
            .i_len     ((g == PIN_XLOCK) ? r_xlen : r_len),
            .o_level_n (pins.levels[g]),
            .o_flip    (pins.flips[g])
        );
    end

    dol_events u_events (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (accept),
        .i_item     (i_in.data),
        .i_pins     (pins),
        .i_obs_mask (r_obs_mask),
        .o_item     (n_out)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // Every accepted sample yields a pending result.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_out_valid)
        else $error("accepted sample produced no result");

    // The result valid only changes through an accepted sample or a taken result.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept && !(r_out_valid && o_out.ready) |=> r_out_valid == $past(r_out_valid))
        else $error("result valid changed without a transaction");

    // An empty result register never stalls the input.
    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> i_in.ready)
        else $error("input stalled with an empty result register");

endmodule

// ----- verif/tb_top.sv -----
// Testbench of the debounce and obstruction latch: random and directed samples checked by a predictor.
`timescale 1ns / 1ps

module tb_top;
    import dol_pkg::*;

    // Bit positions of the obstruction code, and of the warning among the obstruction pins.
    localparam int CODE_X_PLUS   = 0;
    localparam int CODE_X_MINUS  = 1;
    localparam int CODE_MO       = 2;
    localparam int CODE_YLIM_POS = 4;
    localparam int CODE_YLIM_NEG = 5;
    localparam int CODE_MOT_X    = 6;
    localparam int CODE_MOT_Y    = 7;
    localparam int OBS_WARN      = 3;

    // Register index that no register answers to.
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int CNT_LIMIT = (1 << DOL_COUNT_WIDTH) - 1;
    localparam int DRAIN_CYCLES = 4;

    // Keeps the expected state of the latch and the queue of results still to come.
    class latch_scoreboard;
        logic [7:0] obs_mask;
        logic [7:0] len_main;
        logic [7:0] len_xlock;
        logic [4:0] levels;
        int         disagree [NUM_PINS];
        logic [1:0] lock_mask;
        logic       lock_flag;
        logic [7:0] last_code;
        logic [7:0] new_flags;
        logic       code_flag;
        logic       last_warning;
        logic       warning_flag;
        logic       button_flag;
        logic [1:0] air_flag;
        logic       soft_stop_level;
        t_out_item  expected_results [$];
        int         n_errors;

        function new();
            obs_mask        = OBS_MASK_RESET;
            len_main        = DEBOUNCE_RESET;
            len_xlock       = DEBOUNCE_RESET;
            levels          = PIN_RESET_LEVELS;
            foreach (disagree[i]) disagree[i] = 1;
            lock_mask       = '0;
            lock_flag       = 1'b0;
            last_code       = '0;
            new_flags       = '0;
            code_flag       = 1'b0;
            last_warning    = 1'b0;
            warning_flag    = 1'b0;
            button_flag     = 1'b0;
            air_flag        = AIR_NONE;
            soft_stop_level = 1'b1;
            n_errors        = 0;
        endfunction

        // Mirrors a register write; an unknown index changes nothing.
        function void write_reg(logic [1:0] index, logic [7:0] value);
            case (index)
                CFG_OBSTRUCTION_MASK:      obs_mask  = value;
                CFG_DEBOUNCE_LENGTH:       len_main  = value;
                CFG_XLOCK_DEBOUNCE_LENGTH: len_xlock = value;
                default: ;
            endcase
        endfunction

        // Counts one disagreeing sample of a pin; returns 1 when the pin flips.
        function bit debounce(int idx, logic raw, logic [7:0] len);
            if (raw == levels[idx]) begin
                disagree[idx] = 0;
                return 1'b0;
            end
            if (disagree[idx] < CNT_LIMIT) disagree[idx]++;
            if (disagree[idx] >= int'(len)) begin
                levels[idx]   = ~levels[idx];
                disagree[idx] = 0;
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Works out the result of one accepted sample and queues it.
        function void note_sample(t_in_item s);
            t_out_item  r;
            logic [7:0] code;
            logic       stop;

            stop = 1'b0;
            // Acknowledges take effect before the sample itself.
            if (s.ack_events[ACK_LOCK])    lock_flag    = 1'b0;
            if (s.ack_events[ACK_OBS])     code_flag    = 1'b0;
            if (s.ack_events[ACK_WARNING]) warning_flag = 1'b0;
            if (s.ack_events[ACK_BUTTON])  button_flag  = 1'b0;
            if (s.ack_events[ACK_AIR])     air_flag     = AIR_NONE;
            new_flags = new_flags & ~s.ack_new_flags;

            if (debounce(PIN_BUTTON, s.debounce_pins[PIN_BUTTON], len_main))
                button_flag = s.debounce_pins[PIN_BUTTON];
            void'(debounce(PIN_ESTOP, s.debounce_pins[PIN_ESTOP], len_main));
            if (debounce(PIN_XLOCK, s.debounce_pins[PIN_XLOCK], len_xlock))
                lock_flag = 1'b1;
            if (debounce(PIN_YLOCK, s.debounce_pins[PIN_YLOCK], len_main))
                lock_flag = 1'b1;

            // The lock mask follows the lock pins only while the event is pending.
            if (lock_flag) begin
                lock_mask[0] = ~levels[PIN_XLOCK];
                lock_mask[1] = ~levels[PIN_YLOCK];
            end

            code = '0;
            code[CODE_X_PLUS]   = s.obstruction_pins[0];
            code[CODE_X_MINUS]  = s.obstruction_pins[1];
            code[CODE_MO]       = s.obstruction_pins[2];
            code[CODE_YLIM_POS] = ~s.limit_pins[0];
            code[CODE_YLIM_NEG] = ~s.limit_pins[1];
            code[CODE_MOT_X]    = s.motion_obstruct[0];
            code[CODE_MOT_Y]    = s.motion_obstruct[1];
            code = code & obs_mask;
            if (code != last_code) begin
                new_flags = new_flags | ((code ^ last_code) & code);
                last_code = code;
                code_flag = 1'b1;
            end

            if (s.obstruction_pins[OBS_WARN] != last_warning) begin
                last_warning = s.obstruction_pins[OBS_WARN];
                warning_flag = 1'b1;
            end

            if (debounce(PIN_AIR, s.debounce_pins[PIN_AIR], len_main))
                air_flag = {1'b0, s.debounce_pins[PIN_AIR]};

            if (s.soft_stop_pin != soft_stop_level) begin
                soft_stop_level = s.soft_stop_pin;
                if (!s.soft_stop_pin) stop = 1'b1;
            end

            r.debounced_levels  = levels;
            r.machine_lock      = lock_mask;
            r.lock_event        = lock_flag;
            r.obstruction_code  = last_code;
            r.new_obstruction   = new_flags;
            r.obstruction_event = code_flag;
            r.warning_active    = last_warning;
            r.warning_event     = warning_flag;
            r.button_event      = button_flag;
            r.air_event         = air_flag;
            r.stop_request      = stop;
            expected_results.push_back(r);
        endfunction

        function void compare(string field, logic [7:0] exp, logic [7:0] got);
            if (got !== exp) begin
                $error("%s: expected 0x%0h, got 0x%0h", field, exp, got);
                n_errors++;
            end
        endfunction

        // Checks an accepted result against the oldest expectation.
        function void check_result(t_out_item got);
            t_out_item exp;
            if (expected_results.size() == 0) begin
                $error("result transaction with no sample waiting for it");
                n_errors++;
                return;
            end
            exp = expected_results.pop_front();
            compare("debounced_levels", exp.debounced_levels, got.debounced_levels);
            compare("machine_lock", exp.machine_lock, got.machine_lock);
            compare("lock_event", exp.lock_event, got.lock_event);
            compare("obstruction_code", exp.obstruction_code, got.obstruction_code);
            compare("new_obstruction", exp.new_obstruction, got.new_obstruction);
            compare("obstruction_event", exp.obstruction_event, got.obstruction_event);
            compare("warning_active", exp.warning_active, got.warning_active);
            compare("warning_event", exp.warning_event, got.warning_event);
            compare("button_event", exp.button_event, got.button_event);
            compare("air_event", exp.air_event, got.air_event);
            compare("stop_request", exp.stop_request, got.stop_request);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_cfg_we;
    logic [1:0] i_cfg_index;
    logic [7:0] i_cfg_data;

    dol_in_if  in_if ();
    dol_out_if out_if ();

    debounce_obstruction_latch u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_if),
        .o_out       (out_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    latch_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;

    // Slowly changing raw inputs that the random samples walk from.
    logic [4:0] raw_pins;
    logic [3:0] raw_obs;
    logic [1:0] raw_lim;
    logic [1:0] raw_mot;
    logic       raw_soft_stop;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Receiver side: ready is redrawn every cycle.
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Every accepted transaction goes to the scoreboard.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_if.valid && in_if.ready) sb.note_sample(in_if.data);
            if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
        end
    end

    initial begin
        #5ms;
        $display("tb_top: errors");
        $finish;
    end

    function automatic t_in_item mk(logic [4:0] pins, logic [3:0] obs, logic [1:0] lim,
                                    logic [1:0] mot, logic ss, logic [4:0] ack,
                                    logic [7:0] ack_new);
        t_in_item s;
        s.debounce_pins    = pins;
        s.obstruction_pins = obs;
        s.limit_pins       = lim;
        s.motion_obstruct  = mot;
        s.soft_stop_pin    = ss;
        s.ack_events       = ack;
        s.ack_new_flags    = ack_new;
        return s;
    endfunction

    // Random sample around the current raw levels; flags drift and acks come now and then.
    function automatic t_in_item rand_sample(logic [4:0] pins);
        logic [4:0] ack;
        logic [7:0] ack_new;
        if ($urandom_range(5) == 0) raw_obs = 4'($urandom);
        if ($urandom_range(5) == 0) raw_lim = 2'($urandom);
        if ($urandom_range(5) == 0) raw_mot = 2'($urandom);
        if ($urandom_range(7) == 0) raw_soft_stop = ~raw_soft_stop;
        for (int b = 0; b < 5; b++) ack[b] = ($urandom_range(3) == 0);
        ack_new = ($urandom_range(3) == 0) ? 8'($urandom) : 8'h00;
        return mk(pins, raw_obs, raw_lim, raw_mot, raw_soft_stop, ack, ack_new);
    endfunction

    task automatic send(t_in_item s);
        while ($urandom_range(99) < send_idle_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= s;
        @(posedge i_clk);
        while (!in_if.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every expected result has come.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] index, logic [7:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(index, value);
    endtask

    task automatic set_lengths(logic [7:0] mask, logic [7:0] len, logic [7:0] xlen);
        cfg_write(CFG_OBSTRUCTION_MASK, mask);
        cfg_write(CFG_DEBOUNCE_LENGTH, len);
        cfg_write(CFG_XLOCK_DEBOUNCE_LENGTH, xlen);
    endtask

    // Raw pins mostly hold steady runs, with occasional changes and one-sample glitches.
    task automatic run_random(int n);
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(7) == 0) raw_pins[$urandom_range(4)] ^= 1'b1;
            if ($urandom_range(19) == 0)
                send(rand_sample(raw_pins ^ 5'($urandom)));
            else
                send(rand_sample(raw_pins));
        end
    endtask

    // Holds the raw pins at one value so the counters run long.
    task automatic hold_pins(int n, logic [4:0] pins);
        repeat (n) send(rand_sample(pins));
    endtask

    initial begin
        logic [4:0] far_pins;

        sb             = new();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        raw_pins       = PIN_RESET_LEVELS;
        raw_obs        = '0;
        raw_lim        = 2'b11;
        raw_mot        = '0;
        raw_soft_stop  = 1'b1;
        i_rst_n        = 1'b0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = '0;
        i_cfg_data     = '0;
        in_if.valid    = 1'b0;
        in_if.data     = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed samples at reset settings: field extremes, stop edges and acks
        // landing on the same sample that raises the event.
        send(mk(5'h00, 4'h0, 2'b00, 2'b00, 1'b0, 5'h00, 8'h00));
        send(mk(5'h1F, 4'hF, 2'b11, 2'b11, 1'b1, 5'h1F, 8'hFF));
        send(mk(5'h1F, 4'hF, 2'b11, 2'b11, 1'b1, 5'h00, 8'h00));
        send(mk(5'h1F, 4'hF, 2'b11, 2'b11, 1'b0, 5'h00, 8'h00));
        send(mk(5'h1F, 4'h0, 2'b11, 2'b00, 1'b1, 5'h00, 8'hFF));
        send(mk(5'h00, 4'h1, 2'b10, 2'b01, 1'b1, 5'h02, 8'h00));
        send(mk(5'h00, 4'h2, 2'b01, 2'b10, 1'b0, 5'h01, 8'h00));
        send(mk(5'h00, 4'h4, 2'b11, 2'b00, 1'b0, 5'h00, 8'h01));
        send(mk(5'h00, 4'h8, 2'b11, 2'b00, 1'b1, 5'h04, 8'h00));
        send(mk(5'h00, 4'h8, 2'b11, 2'b00, 1'b1, 5'h00, 8'hF0));
        send(mk(5'h1F, 4'h0, 2'b00, 2'b11, 1'b0, 5'h00, 8'h00));
        send(mk(5'h1F, 4'h0, 2'b00, 2'b11, 1'b0, 5'h00, 8'h0F));
        send(mk(5'h1F, 4'h0, 2'b00, 2'b11, 1'b0, 5'h00, 8'h00));
        send(mk(5'h1B, 4'h7, 2'b00, 2'b11, 1'b0, 5'h01, 8'h00));
        send(mk(5'h13, 4'h7, 2'b00, 2'b11, 1'b0, 5'h02, 8'h00));
        send(mk(5'h13, 4'h7, 2'b00, 2'b11, 1'b0, 5'h04, 8'h00));
        send(mk(5'h13, 4'h7, 2'b00, 2'b11, 1'b0, 5'h08, 8'h00));
        send(mk(5'h13, 4'h7, 2'b00, 2'b11, 1'b0, 5'h10, 8'hAA));
        send(mk(5'h0C, 4'h0, 2'b11, 2'b00, 1'b1, 5'h00, 8'h55));
        send(mk(5'h0C, 4'h0, 2'b11, 2'b00, 1'b1, 5'h00, 8'h00));
        send(mk(5'h0C, 4'h0, 2'b11, 2'b00, 1'b1, 5'h1F, 8'hFF));
        wait_drained();

        // Short debounce, partial mask, sender idling; a write to the unused index
        // must leave every register alone.
        set_lengths(8'h5A, 8'd1, 8'd2);
        cfg_write(CFG_UNUSED, 8'hFF);
        send_idle_pct = 66;
        run_random(100);
        // The sender pauses until every result is in, then carries on.
        wait_drained();
        run_random(100);
        wait_drained();

        // Zero length flips on the first disagreeing sample; the receiver stalls.
        set_lengths(8'hFF, 8'd0, 8'd0);
        send_idle_pct  = 0;
        recv_stall_pct = 66;
        run_random(100);
        wait_drained();

        // Longest length with everything masked: run the counters up, then lower
        // the length below the running count so the next disagreement flips.
        set_lengths(8'h00, 8'd255, 8'd255);
        send_idle_pct  = 30;
        recv_stall_pct = 30;
        far_pins = ~sb.levels;
        hold_pins(100, far_pins);
        wait_drained();
        set_lengths(8'hC3, 8'd1, 8'd1);
        hold_pins(5, far_pins);
        wait_drained();

        // Counters reach the top of their range and the pins flip there.
        set_lengths(8'hFF, 8'd255, 8'd255);
        far_pins = ~sb.levels;
        hold_pins(270, far_pins);
        raw_pins = far_pins;
        wait_drained();

        // Separate X lock length, both sides idling at times.
        set_lengths(8'hF7, 8'd3, 8'd1);
        run_random(60);
        wait_drained();

        // Back to full speed.
        set_lengths(8'hFF, 8'd2, 8'd4);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        run_random(60);

        wait_drained();
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end
endmodule

// ----- files.f -----
rtl/core/dol_pkg.sv
rtl/core/dol_in_if.sv
rtl/core/dol_out_if.sv
rtl/core/dol_debounce.sv
rtl/core/dol_events.sv
rtl/core/debounce_obstruction_latch.sv
verif/tb_top.sv
